### rtl/auxiliary_spin_flip_rank_one_update_defines.svh
// Assertion macros for the port checker file of the spin flip block.
// No dependencies; include by bare file name.
`ifndef AUXILIARY_SPIN_FLIP_RANK_ONE_UPDATE_DEFINES_SVH
`define AUXILIARY_SPIN_FLIP_RANK_ONE_UPDATE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define ASFR_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("asfr check failed");

// Next-cycle implication, held off during reset.
`define ASFR_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("asfr check failed");

`endif

### rtl/asfr_pkg.sv
// Shared types, constants and saturation helper for the spin flip block.
// No dependencies.
package asfr_pkg;

  localparam int SITES_DEF     = 64;
  localparam int FRAC_BITS_DEF = 24;
  localparam int RATE_BITS     = 24;
  localparam int RATE_W        = 25;
  localparam int DATA_W        = 32;
  localparam int OP_W          = 33;
  localparam int WIDE_W        = 2 * OP_W;
  localparam int GPOS_W        = 31;
  localparam int GNEG_W        = 25;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 31;
  localparam int ROW_W         = 6;
  localparam int UNI_W         = 24;

  // Stream layout
  localparam int IN_DATA_W  = 72;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 64;
  localparam int IN_COL_LSB   = 6;
  localparam int IN_ENTRY_LSB = 12;
  localparam int IN_UNI_LSB   = 44;
  localparam int IN_SPIN_BIT  = 68;
  localparam int OUT_SPIN_BIT = 32;
  localparam int OUT_FLIP_BIT = 33;
  localparam int OUT_RATE_LSB = 34;

  localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(1) << RATE_BITS;

  typedef enum logic [1:0] {
    CMD_WRITE_ENTRY = 2'd0,
    CMD_WRITE_SPIN  = 2'd1,
    CMD_FLIP        = 2'd2,
    CMD_READ        = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_POS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_NEG = 2'd1;

  localparam logic signed [WIDE_W-1:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [WIDE_W-1:0] SAT_MIN = -66'sd2147483648;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > SAT_MAX) r = 32'sh7fffffff;
    else if (x < SAT_MIN) r = 32'sh80000000;
    else r = x[DATA_W-1:0];
    return r;
  endfunction

endpackage

### rtl/auxiliary_spin_flip_rank_one_update.sv
// Single auxiliary spin flip with rank-one update of two Green's function matrices.
// Depends on asfr_pkg.
//
// Usage: requests enter on the s_axis channel (tuser = command and sector, tdata =
// row, column, entry, uniform fraction, spin). Every request yields exactly one result
// on m_axis: entry and spin read after the command, flip outcome and heat-bath rate.
// gamma_pos / gamma_neg are set through cfg_we / cfg_index / cfg_data; the user is to
// write them only while idle, which the block itself does not enforce. Entry write,
// spin write and read pass through the execute, fetch and response states to the
// output register. A rejected flip adds the diagonal read, the ratio products and the
// rate division, one quotient bit per cycle. An accepted flip runs, per matrix, a
// 56-step alpha division (32 + FRAC_BITS), a copy of column and row, and for each
// entry the read, product, weight and write states through one shared multiplier and
// the single matrix port. One request is in flight at a time; s_axis_tready is high
// only in the idle state. A finished result sits in the output register, so the next
// request is taken while the receiver stalls; that request then holds before its own
// result until the register frees. Reset clears the spins (all +1), the flip factors
// and the control; the matrices are undefined until written.
module auxiliary_spin_flip_rank_one_update #(
  parameter int SITES     = asfr_pkg::SITES_DEF,
  parameter int FRAC_BITS = asfr_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // row[5:0], col[11:6], entry_value[43:12], uniform[67:44], spin_down[68]
  input  logic [asfr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // cmd[1:0], sector[2]
  input  logic [asfr_pkg::IN_USER_W-1:0]   s_axis_tuser,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // read_value[31:0], spin_down_now[32], flipped[33], accept_rate[58:34]
  output logic [asfr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_we,
  input  logic [asfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [asfr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import asfr_pkg::*;

  localparam int IDX_W  = $clog2(SITES);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = 2 ** ADDR_W;
  localparam int DVD_W  = DATA_W + FRAC_BITS;
  localparam int CNT_W  = $clog2(DVD_W + 1);
  localparam logic signed [WIDE_W-1:0] ONE_W  = 66'sd1 <<< FRAC_BITS;
  localparam logic signed [WIDE_W-1:0] SQ_ONE = ONE_W <<< FRAC_BITS;
  localparam logic signed [OP_W-1:0]   ONE_OP = ONE_W[OP_W-1:0];

  typedef enum logic [4:0] {
    ST_IDLE, ST_EXEC, ST_DIAG_RD, ST_R_UP, ST_R_DN, ST_R_DW, ST_D_MUL,
    ST_RATE_CHK, ST_RATE_DIV, ST_DECIDE, ST_ALPHA_INIT, ST_ALPHA_DIV,
    ST_COPY, ST_COPY_END, ST_UPD_RD, ST_UPD_P, ST_UPD_W, ST_UPD_WR,
    ST_FETCH, ST_RESP
  } state_t;

  state_t state;

  // Latched request
  cmd_t                     u_cmd;
  logic                     u_sector;
  logic [ROW_W-1:0]         u_row;
  logic [ROW_W-1:0]         u_col;
  logic signed [DATA_W-1:0] u_entry;
  logic [UNI_W-1:0]         u_uniform;
  logic                     u_spin;

  logic [GPOS_W-1:0]        gamma_pos;
  logic signed [GNEG_W-1:0] gamma_neg;
  logic [SITES-1:0]         spin_q;

  // Flip datapath registers
  logic signed [OP_W-1:0]   a_up, a_dw;
  logic signed [DATA_W-1:0] gd_dn;
  logic signed [WIDE_W-1:0] r_up, r_dw;
  logic signed [WIDE_W-1:0] prod;
  logic [WIDE_W-1:0]        rem, dvs;
  logic [DVD_W-1:0]         dvd, quo;
  logic [CNT_W-1:0]         cnt;
  logic                     q_neg;
  logic [RATE_W-1:0]        rate;
  logic                     flipped;
  logic                     sec;
  logic signed [DATA_W-1:0] alpha;
  logic signed [DATA_W-1:0] gq;
  logic [IDX_W-1:0]         cp_k, cp_kd, ui, uj;
  logic                     cp_row, cp_rowd, cp_v;

  // Output register
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_spin, out_flip;
  logic [RATE_W-1:0]        out_rate;

  // Memories
  logic signed [DATA_W-1:0] green_up [DEPTH];
  logic signed [DATA_W-1:0] green_dn [DEPTH];
  logic signed [OP_W-1:0]   colbuf [SITES];
  logic signed [DATA_W-1:0] rowbuf [SITES];
  logic signed [DATA_W-1:0] up_rdata, dn_rdata, rdata_sec;
  logic signed [OP_W-1:0]   col_q;
  logic signed [DATA_W-1:0] row_q;
  logic [ADDR_W-1:0]        rd_addr, wr_addr;
  logic                     wr_en_up, wr_en_dn;
  logic signed [DATA_W-1:0] wr_data;

  // Combinational helpers
  logic                     req_ok;
  logic                     row_ok, col_ok;
  logic [IDX_W-1:0]         row_idx, col_idx;
  logic signed [OP_W-1:0]   op_x, op_y;
  logic [WIDE_W-1:0]        num_c, den_c;
  logic signed [WIDE_W-1:0] den_sum;
  logic [WIDE_W-1:0]        rem_sh, rem_step;
  logic                     div_ge;
  logic [DVD_W-1:0]         quo_step;
  logic signed [OP_W-1:0]   a_cur;
  logic signed [WIDE_W-1:0] r_cur;
  logic [WIDE_W-1:0]        r_mag;
  logic [OP_W-1:0]          a_mag;
  logic signed [DATA_W-1:0] alpha_sat, p_val, upd_val;
  logic signed [WIDE_W-1:0] w_sum;
  logic signed [OP_W-1:0]   col_wdata;
  logic signed [OP_W-1:0]   gp_ext, gn_ext;

  assign req_ok  = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign row_ok  = (int'(u_row) < SITES);
  assign col_ok  = (int'(u_col) < SITES);
  assign row_idx = IDX_W'(u_row);
  assign col_idx = IDX_W'(u_col);
  assign rdata_sec = sec ? dn_rdata : up_rdata;
  assign gp_ext  = OP_W'(gamma_pos);
  assign gn_ext  = OP_W'(gamma_neg);
  assign a_cur   = sec ? a_dw : a_up;
  assign r_cur   = sec ? r_dw : r_up;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W - OUT_RATE_LSB - RATE_W){1'b0}},
                          out_rate, out_flip, out_spin, out_value};

  // Shared multiplier operand select
  always_comb begin
    op_x = '0;
    op_y = '0;
    case (state)
      ST_R_UP: begin
        op_x = ONE_OP - OP_W'(up_rdata);
        op_y = a_up;
      end
      ST_R_DN: begin
        op_x = ONE_OP - OP_W'(gd_dn);
        op_y = a_dw;
      end
      ST_D_MUL: begin
        op_x = OP_W'(sat32(r_up));
        op_y = OP_W'(sat32(r_dw));
      end
      ST_UPD_P: begin
        op_x = col_q;
        op_y = OP_W'(row_q);
      end
      ST_UPD_W: begin
        op_x = OP_W'(p_val);
        op_y = OP_W'(alpha);
      end
      default: begin
        op_x = '0;
        op_y = '0;
      end
    endcase
  end

  // Rate bounds, shared restoring divider step, update arithmetic
  always_comb begin
    num_c    = prod[WIDE_W-1] ? WIDE_W'(-prod) : WIDE_W'(prod);
    den_sum  = SQ_ONE + prod;
    den_c    = den_sum[WIDE_W-1] ? WIDE_W'(-den_sum) : WIDE_W'(den_sum);
    rem_sh   = {rem[WIDE_W-2:0], dvd[DVD_W-1]};
    div_ge   = (rem_sh >= dvs);
    rem_step = div_ge ? (rem_sh - dvs) : rem_sh;
    quo_step = {quo[DVD_W-2:0], div_ge};
    r_mag    = r_cur[WIDE_W-1] ? WIDE_W'(-r_cur) : WIDE_W'(r_cur);
    a_mag    = a_cur[OP_W-1] ? OP_W'(-a_cur) : OP_W'(a_cur);
    if (!q_neg) begin
      alpha_sat = (quo_step > DVD_W'(32'h7fffffff)) ? 32'sh7fffffff
                                                    : quo_step[DATA_W-1:0];
    end else begin
      alpha_sat = (quo_step > DVD_W'(32'h80000000)) ? 32'sh80000000
                                                    : 32'(32'd0 - quo_step[DATA_W-1:0]);
    end
    p_val     = sat32(prod >>> FRAC_BITS);
    w_sum     = WIDE_W'(gq) + (prod >>> FRAC_BITS);
    upd_val   = sat32(w_sum);
    col_wdata = OP_W'(rdata_sec) - ((cp_kd == row_idx) ? ONE_OP : OP_W'(0));
  end

  // Matrix port address and write select
  always_comb begin
    rd_addr  = {row_idx, col_idx};
    wr_addr  = {row_idx, col_idx};
    wr_data  = u_entry;
    wr_en_up = 1'b0;
    wr_en_dn = 1'b0;
    case (state)
      ST_EXEC: begin
        if (u_cmd == CMD_WRITE_ENTRY && row_ok && col_ok) begin
          wr_en_up = !u_sector;
          wr_en_dn = u_sector;
        end
      end
      ST_DIAG_RD: rd_addr = {row_idx, row_idx};
      ST_COPY:    rd_addr = cp_row ? {row_idx, cp_k} : {cp_k, row_idx};
      ST_UPD_RD:  rd_addr = {ui, uj};
      ST_UPD_WR: begin
        wr_addr  = {ui, uj};
        wr_data  = upd_val;
        wr_en_up = !sec;
        wr_en_dn = sec;
      end
      default: rd_addr = {row_idx, col_idx};
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en_up) green_up[wr_addr] <= wr_data;
    up_rdata <= green_up[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en_dn) green_dn[wr_addr] <= wr_data;
    dn_rdata <= green_dn[rd_addr];
  end

  // Pre-update copies of column s (minus identity) and row s
  always_ff @(posedge clk) begin
    if (cp_v && !cp_rowd) colbuf[cp_kd] <= col_wdata;
    col_q <= colbuf[ui];
  end

  always_ff @(posedge clk) begin
    if (cp_v && cp_rowd) rowbuf[cp_kd] <= rdata_sec;
    row_q <= rowbuf[uj];
  end

  always_ff @(posedge clk) begin
    prod    <= op_x * op_y;
    cp_kd   <= cp_k;
    cp_rowd <= cp_row;
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      spin_q    <= '0;
      gamma_pos <= '0;
      gamma_neg <= '0;
      cp_v      <= 1'b0;
    end else begin
      cp_v <= (state == ST_COPY);
      // Configuration
      if (cfg_we) begin
        if (cfg_index == CFG_GAMMA_POS) gamma_pos <= cfg_data[GPOS_W-1:0];
        else if (cfg_index == CFG_GAMMA_NEG) gamma_neg <= cfg_data[GNEG_W-1:0];
      end
      if (out_valid && m_axis_tready) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (req_ok) begin
            u_cmd     <= cmd_t'(s_axis_tuser[1:0]);
            u_sector  <= s_axis_tuser[2];
            u_row     <= s_axis_tdata[ROW_W-1:0];
            u_col     <= s_axis_tdata[IN_COL_LSB +: ROW_W];
            u_entry   <= s_axis_tdata[IN_ENTRY_LSB +: DATA_W];
            u_uniform <= s_axis_tdata[IN_UNI_LSB +: UNI_W];
            u_spin    <= s_axis_tdata[IN_SPIN_BIT];
            state     <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          rate    <= '0;
          flipped <= 1'b0;
          sec     <= 1'b0;
          a_up    <= spin_q[row_idx] ? gp_ext : gn_ext;
          a_dw    <= spin_q[row_idx] ? gn_ext : gp_ext;
          state   <= ST_FETCH;
          if (u_cmd == CMD_WRITE_SPIN && row_ok) spin_q[row_idx] <= u_spin;
          if (u_cmd == CMD_FLIP && row_ok) state <= ST_DIAG_RD;
        end
        ST_DIAG_RD: state <= ST_R_UP;
        ST_R_UP: begin
          gd_dn <= dn_rdata;
          state <= ST_R_DN;
        end
        ST_R_DN: begin
          r_up  <= ONE_W + (prod >>> FRAC_BITS);
          state <= ST_R_DW;
        end
        ST_R_DW: begin
          r_dw  <= ONE_W + (prod >>> FRAC_BITS);
          state <= ST_D_MUL;
        end
        ST_D_MUL: state <= ST_RATE_CHK;
        ST_RATE_CHK: begin
          // prod now holds d = r_up * r_dw
          if (den_c == '0 || num_c >= den_c) begin
            rate  <= RATE_ONE;
            state <= ST_DECIDE;
          end else begin
            rem   <= num_c;
            dvs   <= den_c;
            dvd   <= '0;
            quo   <= '0;
            cnt   <= CNT_W'(RATE_BITS);
            state <= ST_RATE_DIV;
          end
        end
        ST_RATE_DIV: begin
          rem <= rem_step;
          dvd <= dvd << 1;
          quo <= quo_step;
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            rate  <= RATE_W'(quo_step[RATE_BITS-1:0]);
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (RATE_W'(u_uniform) < rate) begin
            flipped <= 1'b1;
            state   <= ST_ALPHA_INIT;
          end else begin
            state <= ST_FETCH;
          end
        end
        ST_ALPHA_INIT: begin
          // alpha = a * 2^F / r, truncated toward zero
          rem   <= '0;
          dvs   <= r_mag;
          dvd   <= DVD_W'(a_mag) << FRAC_BITS;
          quo   <= '0;
          cnt   <= CNT_W'(DVD_W);
          q_neg <= a_cur[OP_W-1] ^ r_cur[WIDE_W-1];
          state <= ST_ALPHA_DIV;
        end
        ST_ALPHA_DIV: begin
          rem <= rem_step;
          dvd <= dvd << 1;
          quo <= quo_step;
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            alpha  <= alpha_sat;
            cp_k   <= '0;
            cp_row <= 1'b0;
            state  <= ST_COPY;
          end
        end
        ST_COPY: begin
          // Walk column s, then row s, one read a cycle
          if (cp_k == IDX_W'(SITES - 1)) begin
            cp_k <= '0;
            if (cp_row) state <= ST_COPY_END;
            else cp_row <= 1'b1;
          end else begin
            cp_k <= cp_k + 1'b1;
          end
        end
        ST_COPY_END: begin
          ui    <= '0;
          uj    <= '0;
          state <= ST_UPD_RD;
        end
        ST_UPD_RD: state <= ST_UPD_P;
        ST_UPD_P: begin
          gq    <= rdata_sec;
          state <= ST_UPD_W;
        end
        ST_UPD_W: state <= ST_UPD_WR;
        ST_UPD_WR: begin
          state <= ST_UPD_RD;
          if (uj == IDX_W'(SITES - 1)) begin
            uj <= '0;
            if (ui == IDX_W'(SITES - 1)) begin
              ui <= '0;
              if (!sec) begin
                sec   <= 1'b1;
                state <= ST_ALPHA_INIT;
              end else begin
                spin_q[row_idx] <= ~spin_q[row_idx];
                state           <= ST_FETCH;
              end
            end else begin
              ui <= ui + 1'b1;
            end
          end else begin
            uj <= uj + 1'b1;
          end
        end
        ST_FETCH: state <= ST_RESP;
        ST_RESP: begin
          // Hold until the output register is free
          if (!out_valid || m_axis_tready) begin
            out_valid <= 1'b1;
            out_value <= (row_ok && col_ok) ? (u_sector ? dn_rdata : up_rdata) : '0;
            out_spin  <= row_ok ? spin_q[row_idx] : 1'b0;
            out_flip  <= flipped;
            out_rate  <= rate;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/asfr_checker.sv
// Port-level checks for the spin flip block, bound to the top level.
// Depends on asfr_pkg and the assertion macro header.
`include "auxiliary_spin_flip_rank_one_update_defines.svh"

module asfr_port_checks (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [asfr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready
);
  import asfr_pkg::*;

  logic [RATE_W-1:0] rate;
  logic              flip;

  assign rate = m_axis_tdata[OUT_RATE_LSB +: RATE_W];
  assign flip = m_axis_tdata[OUT_FLIP_BIT];

  // One request in flight: busy right after a request is taken
  `ASFR_ASSERT_NEXT(a_busy_after_req, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `ASFR_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `ASFR_ASSERT_IMPLY(a_rate_max, clk, rst, m_axis_tvalid, rate <= RATE_ONE)
  `ASFR_ASSERT_IMPLY(a_flip_needs_rate, clk, rst, m_axis_tvalid && flip, rate != '0)

endmodule

bind auxiliary_spin_flip_rank_one_update asfr_port_checks u_asfr_port_checks (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

### tb/asfr_checker.sv
// Checker for the spin flip block: watches the request, result and register ports,
// keeps its own copy of both matrices, the spins and the flip factors, and compares.
// Depends on asfr_pkg.
module asfr_checker
  import asfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending
);

  localparam int N = SITES_DEF;
  localparam int F = FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << F;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic              spin_down_now;
    logic              flipped;
    logic [RATE_W-1:0] accept_rate;
  } outcome_t;

  longint    green_up [N*N];
  longint    green_dn [N*N];
  bit        spin_dn  [N];
  longint    flip_pos;
  longint    flip_neg;
  outcome_t  expected_q [$];
  int        bad_count;

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint ratio_factor(longint g, longint a);
    return ONE + (((ONE - g) * a) >>> F);
  endfunction

  // Rank-one update of one sector around site s, using the matrix as it was before.
  function automatic void rank_update(bit sec, int s, longint a, longint r);
    longint alpha, p, w, cur;
    longint colv [N];
    longint rowv [N];
    alpha = clamp32((a * ONE) / r);
    for (int i = 0; i < N; i++) begin
      colv[i] = (sec ? green_dn[i*N+s] : green_up[i*N+s]) - ((i == s) ? ONE : 0);
      rowv[i] = sec ? green_dn[s*N+i] : green_up[s*N+i];
    end
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        p = clamp32((colv[i] * rowv[j]) >>> F);
        w = (p * alpha) >>> F;
        cur = sec ? green_dn[i*N+j] : green_up[i*N+j];
        if (sec) green_dn[i*N+j] = clamp32(cur + w);
        else green_up[i*N+j] = clamp32(cur + w);
      end
    end
  endfunction

  function automatic outcome_t predict_request(logic [IN_DATA_W-1:0] d,
                                               logic [IN_USER_W-1:0] u);
    outcome_t o;
    cmd_t op;
    bit sec;
    int row, col, s;
    longint a_up, a_dn, r_up, r_dn, prod;
    longint unsigned num, den, rem;
    logic [RATE_W-1:0] rate;
    op   = cmd_t'(u[1:0]);
    sec  = u[2];
    row  = d[ROW_W-1:0];
    col  = d[IN_COL_LSB +: ROW_W];
    rate = '0;
    o.flipped = 1'b0;
    case (op)
      CMD_WRITE_ENTRY: begin
        if (sec) green_dn[row*N+col] = longint'($signed(d[IN_ENTRY_LSB +: DATA_W]));
        else green_up[row*N+col] = longint'($signed(d[IN_ENTRY_LSB +: DATA_W]));
      end
      CMD_WRITE_SPIN: spin_dn[row] = d[IN_SPIN_BIT];
      CMD_FLIP: begin
        s = row;
        a_up = spin_dn[s] ? flip_pos : flip_neg;
        a_dn = spin_dn[s] ? flip_neg : flip_pos;
        r_up = ratio_factor(green_up[s*N+s], a_up);
        r_dn = ratio_factor(green_dn[s*N+s], a_dn);
        prod = clamp32(r_up) * clamp32(r_dn);
        num = (prod < 0) ? longint'(-prod) : prod;
        den = ((ONE * ONE + prod) < 0) ? longint'(-(ONE * ONE + prod)) : ONE * ONE + prod;
        if (den == 0 || num >= den) begin
          rate = RATE_ONE;
        end else begin
          rem = num;
          for (int k = 0; k < RATE_BITS; k++) begin
            rem  = rem << 1;
            rate = rate << 1;
            if (rem >= den) begin
              rem = rem - den;
              rate[0] = 1'b1;
            end
          end
        end
        if (RATE_W'(d[IN_UNI_LSB +: UNI_W]) < rate) begin
          o.flipped = 1'b1;
          rank_update(1'b0, s, a_up, r_up);
          rank_update(1'b1, s, a_dn, r_dn);
          spin_dn[s] = ~spin_dn[s];
        end
      end
      default: ;
    endcase
    o.read_value    = DATA_W'(sec ? green_dn[row*N+col] : green_up[row*N+col]);
    o.spin_down_now = spin_dn[row];
    o.accept_rate   = rate;
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t want, got;
    if (rst) begin
      for (int i = 0; i < N; i++) spin_dn[i] = 1'b0;
      flip_pos = 0;
      flip_neg = 0;
      expected_q.delete();
      bad_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_GAMMA_POS) flip_pos = longint'(cfg_data[GPOS_W-1:0]);
        else if (cfg_index == CFG_GAMMA_NEG)
          flip_neg = longint'($signed(cfg_data[GNEG_W-1:0]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[DATA_W-1:0], m_axis_tdata[OUT_SPIN_BIT],
               m_axis_tdata[OUT_FLIP_BIT], m_axis_tdata[OUT_RATE_LSB +: RATE_W]};
        if (expected_q.size() == 0) begin
          bad_count++;
          if (bad_count <= 10) $display("result with no request waiting: %h", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            bad_count++;
            if (bad_count <= 10)
              $display("mismatch: value %h/%h spin %b/%b flip %b/%b rate %h/%h (exp/act)",
                       want.read_value, got.read_value, want.spin_down_now,
                       got.spin_down_now, want.flipped, got.flipped,
                       want.accept_rate, got.accept_rate);
          end
        end
      end
      // Predict after retiring, so a same-edge result always pairs with older work.
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(predict_request(s_axis_tdata, s_axis_tuser));
    end
    pending    <= expected_q.size();
    mismatches <= bad_count;
  end

endmodule

### tb/tb_auxiliary_spin_flip_rank_one_update.sv
// Top of the spin flip testbench: clock, reset, request and register stimulus,
// random stalls on both channels, and the verdict. Depends on asfr_pkg,
// asfr_checker and the block itself.
module tb_auxiliary_spin_flip_rank_one_update;
  import asfr_pkg::*;

  logic                  clk;
  logic                  rst;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    pending;
  bit                    gaps_on;
  int                    rx_hold = 0;

  auxiliary_spin_flip_rank_one_update dut (
    .clk(clk), .rst(rst),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  asfr_checker scoreboard (
    .clk(clk), .rst(rst),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop: covers the matrix fill plus every request being an accepted flip
  // several times over.
  initial begin
    #240_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Receiver: stall in random bursts while gaps are on, otherwise always ready.
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      rx_hold <= $urandom_range(1, 12);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Send one request; optionally drop valid for a burst first, then hold it
  // until the block takes the request. Valid stays high afterwards.
  task automatic send_request(cmd_t op, bit sec, int row, int col,
                              logic [31:0] entry, logic [23:0] frac, bit spin);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {sec, op};
    s_axis_tdata  <= IN_DATA_W'({spin, frac, entry, 6'(col), 6'(row)});
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Drop valid and hold until every request has its result back.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Mostly Green's-function-sized values, now and then any 32-bit word.
  function automatic logic [31:0] pick_entry();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
  endfunction

  // Random traffic: writes and reads dominate, flips are limited since an
  // accepted one rewrites both matrices.
  task automatic random_phase(int count);
    int pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      send_request(pick < 35 ? CMD_WRITE_ENTRY : pick < 50 ? CMD_WRITE_SPIN :
                   pick < 70 ? CMD_FLIP : CMD_READ,
                   $urandom_range(0, 1), $urandom_range(0, 63), $urandom_range(0, 63),
                   pick_entry(), $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 1));
    end
  endtask

  initial begin
    rst = 1'b1;
    gaps_on = 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Typical factors, lambda near 0.5: exp(1)-1 in Q7.24 and exp(-1)-1 in signed Q1.24.
    write_reg(CFG_GAMMA_POS, 31'd28_827_010);
    write_reg(CFG_GAMMA_NEG, 31'(-25'sd10_605_334));
    write_reg(2'd2, 31'h7FFF_FFFF);
    write_reg(2'd3, 31'h1234_5678);

    // Fill both matrices first: every command reads an entry back, and a flip
    // touches the whole matrix, so nothing may stay unwritten.
    for (int sec = 0; sec < 2; sec++)
      for (int r = 0; r < 64; r++)
        for (int c = 0; c < 64; c++)
          send_request(CMD_WRITE_ENTRY, sec, r, c, pick_entry(), '0, 1'b0);

    // Directed: field extremes, both spins, each operation.
    send_request(CMD_WRITE_ENTRY, 1'b0, 0, 63, 32'h7FFF_FFFF, 24'hFFFFFF, 1'b1);
    send_request(CMD_WRITE_ENTRY, 1'b1, 63, 0, 32'h8000_0000, 24'h0, 1'b0);
    send_request(CMD_READ, 1'b0, 0, 63, 32'hFFFF_FFFF, 24'hFFFFFF, 1'b1);
    send_request(CMD_READ, 1'b1, 63, 0, 32'h0, 24'h0, 1'b0);
    send_request(CMD_WRITE_SPIN, 1'b0, 63, 63, 32'h0, 24'h0, 1'b1);
    send_request(CMD_READ, 1'b1, 63, 63, 32'h0, 24'h0, 1'b0);
    send_request(CMD_WRITE_SPIN, 1'b1, 63, 0, 32'h0, 24'h0, 1'b0);
    // Flips at site 5 with the largest and the smallest uniform, to favour rejection and acceptance.
    send_request(CMD_FLIP, 1'b0, 5, 5, 32'h0, 24'hFFFFFF, 1'b0);
    send_request(CMD_FLIP, 1'b1, 5, 7, 32'h0, 24'h0, 1'b0);
    send_request(CMD_FLIP, 1'b0, 5, 9, 32'h0, 24'h0, 1'b0);
    send_request(CMD_READ, 1'b0, 5, 5, 32'h0, 24'h0, 1'b0);
    drain();

    // Extreme factors; with gamma_neg at -1.0 a zero up-diagonal gives a zero factor.
    write_reg(CFG_GAMMA_POS, 31'h7FFF_FFFF);
    write_reg(CFG_GAMMA_NEG, 31'(-25'sd16_777_216));
    send_request(CMD_WRITE_ENTRY, 1'b0, 10, 10, 32'h0, 24'h0, 1'b0);
    send_request(CMD_WRITE_SPIN, 1'b0, 10, 10, 32'h0, 24'h0, 1'b0);
    send_request(CMD_FLIP, 1'b0, 10, 10, 32'h0, 24'h0, 1'b0);
    send_request(CMD_FLIP, 1'b1, 11, 11, 32'h0, 24'h0, 1'b0);
    random_phase(35);
    drain();

    // Both factors zero: rate of exactly one half everywhere.
    write_reg(CFG_GAMMA_POS, 31'd0);
    write_reg(CFG_GAMMA_NEG, 31'd0);
    send_request(CMD_FLIP, 1'b0, 20, 3, 32'h0, 24'h7FFFFF, 1'b0);
    send_request(CMD_FLIP, 1'b0, 20, 3, 32'h0, 24'h800000, 1'b0);
    random_phase(30);
    drain();

    // Back to typical factors; the tail runs without any stalls.
    write_reg(CFG_GAMMA_POS, 31'd28_827_010);
    write_reg(CFG_GAMMA_NEG, 31'(-25'sd10_605_334));
    random_phase(45);
    gaps_on = 1'b0;
    random_phase(30);
    drain();
    repeat (50) @(posedge clk);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
